/* design/multichannel_uart_ring_buffers_core_defines.svh */
// ----------------------------------------------------------------------------
// Multichannel UART ring buffers: assertion macros
// Shared concurrent assertion forms used by the core's checks.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_UART_RING_BUFFERS_CORE_DEFINES_SVH
`define MULTICHANNEL_UART_RING_BUFFERS_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCURB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCURB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mcurb_pkg.sv */
// ----------------------------------------------------------------------------
// Multichannel UART ring buffers: package
// Sizes, operation codes, controller states and ring pointer helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcurb_pkg;

  localparam int CHANNELS  = 4;
  localparam int RX_DEPTH  = 1024;
  localparam int TX_DEPTH  = 128;

  localparam int CH_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int ERR_W     = 4;
  localparam int FREE_W    = 7;
  localparam int FREE_MAX  = (1 << FREE_W) - 1;

  localparam int RX_PTR_W  = $clog2(RX_DEPTH);
  localparam int TX_PTR_W  = $clog2(TX_DEPTH);
  localparam int FREE_CALC_W = (TX_PTR_W + 1 > FREE_W + 1) ? TX_PTR_W + 1 : FREE_W + 1;

  localparam logic [1:0] OP_LINE  = 2'd0;
  localparam logic [1:0] OP_PUT   = 2'd1;
  localparam logic [1:0] OP_GET   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [CH_W-1:0]   channel;
    logic              status_received;
    logic [ERR_W-1:0]  status_errors;
    logic              status_tx_empty;
    logic [BYTE_W-1:0] data_in;
  } item_t;

  function automatic logic [RX_PTR_W-1:0] inc_rx(input logic [RX_PTR_W-1:0] p);
    logic [RX_PTR_W-1:0] q;
    q = (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + RX_PTR_W'(1);
    return q;
  endfunction

  function automatic logic [TX_PTR_W-1:0] inc_tx(input logic [TX_PTR_W-1:0] p);
    logic [TX_PTR_W-1:0] q;
    q = (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + TX_PTR_W'(1);
    return q;
  endfunction

endpackage

/* design/multichannel_uart_ring_buffers_core.sv */
// ----------------------------------------------------------------------------
// Multichannel UART ring buffers core
// A request is accepted in idle, then passes the pointer lookup and memory read,
// then commit, after which out_tvalid rises; only one request is in flight at a
// time, and a result waiting on out_tready holds the next one in commit.
// Reset: synchronous active-low rst_n zeroes all ring pointers and interrupt
// enables at once; ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multichannel_uart_ring_buffers_core_defines.svh"

module multichannel_uart_ring_buffers_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // status_received[0], status_errors[4:1], status_tx_empty[5], data_in[13:6]
  input  logic [15:0] in_tdata,
  // opcode[1:0], channel[3:2]
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_byte[7:0], send_byte[15:8], tx_irq_enable[16], rx_empty[17],
  // tx_free[24:18], rx_dropped_oldest[25], tx_overflow[26]
  output logic [31:0] out_tdata,
  // read_valid[0], send_valid[1]
  output logic [1:0]  out_tuser
);

  mcurb_pkg::cmd_t  cmd;
  mcurb_pkg::item_t item;

  always_comb begin
    item.opcode          = in_tuser[1:0];
    item.channel         = in_tuser[3:2];
    item.status_received = in_tdata[0];
    item.status_errors   = in_tdata[4:1];
    item.status_tx_empty = in_tdata[5];
    item.data_in         = in_tdata[13:6];
  end

  mcurb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mcurb_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .item      (item),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  `MCURB_ASSERT_NEXT(a_lookup_after_accept, in_tvalid && in_tready, cmd.rd_issue, "no lookup")
  `MCURB_ASSERT_NEXT(a_valid_after_commit, cmd.commit, out_tvalid, "no result after commit")
  `MCURB_ASSERT_SAME(a_single_step, 1'b1, $onehot0({cmd.load, cmd.rd_issue, cmd.commit}), "overlap")
  `MCURB_ASSERT_SAME(a_read_send_exclusive, out_tvalid, !(&out_tuser), "read and send both valid")

endmodule

/* design/mcurb_ctrl.sv */
// ----------------------------------------------------------------------------
// Multichannel UART ring buffers: controller
// Sequences accept, pointer lookup and commit for one request at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcurb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output mcurb_pkg::cmd_t  cmd
);

  mcurb_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcurb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      mcurb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = mcurb_pkg::ST_LOOKUP;
        end
      end
      mcurb_pkg::ST_LOOKUP: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = mcurb_pkg::ST_COMMIT;
      end
      mcurb_pkg::ST_COMMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = mcurb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcurb_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* design/mcurb_dpath.sv */
// ----------------------------------------------------------------------------
// Multichannel UART ring buffers: datapath
// Request register, per-channel ring pointers, ring memories, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcurb_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  mcurb_pkg::cmd_t  cmd,
  input  mcurb_pkg::item_t item,
  output logic [31:0]      out_tdata,
  output logic [1:0]       out_tuser
);

  localparam int RX_ADDR_W = mcurb_pkg::CH_W + mcurb_pkg::RX_PTR_W;
  localparam int TX_ADDR_W = mcurb_pkg::CH_W + mcurb_pkg::TX_PTR_W;

  logic [1:0]                     op_r;
  logic [mcurb_pkg::CH_W-1:0]     ch_r;
  logic                           rcv_r;
  logic                           err_r;
  logic                           txe_r;
  logic [mcurb_pkg::BYTE_W-1:0]   data_r;

  logic [mcurb_pkg::RX_PTR_W-1:0] rx_wp_r [mcurb_pkg::CHANNELS];
  logic [mcurb_pkg::RX_PTR_W-1:0] rx_rp_r [mcurb_pkg::CHANNELS];
  logic [mcurb_pkg::TX_PTR_W-1:0] tx_wp_r [mcurb_pkg::CHANNELS];
  logic [mcurb_pkg::TX_PTR_W-1:0] tx_rp_r [mcurb_pkg::CHANNELS];
  logic                           irq_r   [mcurb_pkg::CHANNELS];

  logic [mcurb_pkg::BYTE_W-1:0]   rx_mem [1 << RX_ADDR_W];
  logic [mcurb_pkg::BYTE_W-1:0]   tx_mem [1 << TX_ADDR_W];
  logic [mcurb_pkg::BYTE_W-1:0]   rx_rdata_r;
  logic [mcurb_pkg::BYTE_W-1:0]   tx_rdata_r;

  logic [31:0]                    out_tdata_r;
  logic [1:0]                     out_tuser_r;

  logic                           ch_ok;
  logic [mcurb_pkg::RX_PTR_W-1:0] rx_wp, rx_rp, rx_wp_nxt, rx_rp_nxt, rx_w1;
  logic [mcurb_pkg::TX_PTR_W-1:0] tx_wp, tx_rp, tx_wp_nxt, tx_rp_nxt;
  logic                           irq_nxt;
  logic                           rx_we, tx_we;
  logic [mcurb_pkg::BYTE_W-1:0]   rbyte, sbyte;
  logic                           rvalid, svalid, dropped, ovf, rx_empty;
  logic [mcurb_pkg::FREE_CALC_W-1:0] free_w, free_r, free_calc;
  logic [mcurb_pkg::FREE_W-1:0]   free_sat;
  logic [31:0]                    tdata_nxt;
  logic [1:0]                     tuser_nxt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= item.opcode;
      ch_r   <= item.channel;
      rcv_r  <= item.status_received;
      err_r  <= |item.status_errors;
      txe_r  <= item.status_tx_empty;
      data_r <= item.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rx_rdata_r <= rx_mem[{ch_r, rx_rp_r[ch_r]}];
      tx_rdata_r <= tx_mem[{ch_r, tx_rp_r[ch_r]}];
    end
    if (rx_we) begin
      rx_mem[{ch_r, rx_wp}] <= data_r;
    end
    if (tx_we) begin
      tx_mem[{ch_r, tx_wp}] <= data_r;
    end
  end

  always_comb begin
    ch_ok     = int'(ch_r) < mcurb_pkg::CHANNELS;
    rx_wp     = rx_wp_r[ch_r];
    rx_rp     = rx_rp_r[ch_r];
    tx_wp     = tx_wp_r[ch_r];
    tx_rp     = tx_rp_r[ch_r];
    rx_wp_nxt = rx_wp;
    rx_rp_nxt = rx_rp;
    tx_wp_nxt = tx_wp;
    tx_rp_nxt = tx_rp;
    irq_nxt   = irq_r[ch_r];
    rx_w1     = mcurb_pkg::inc_rx(rx_wp);
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    rbyte     = '0;
    sbyte     = '0;
    rvalid    = 1'b0;
    svalid    = 1'b0;
    dropped   = 1'b0;
    ovf       = 1'b0;
    case (op_r)
      mcurb_pkg::OP_LINE: begin
        if (!err_r && rcv_r) begin
          rx_we     = 1'b1;
          rx_wp_nxt = rx_w1;
          if (rx_w1 == rx_rp) begin
            rx_rp_nxt = mcurb_pkg::inc_rx(rx_rp);
            dropped   = 1'b1;
          end
        end
        if (txe_r) begin
          if (tx_rp != tx_wp) begin
            sbyte     = tx_rdata_r;
            svalid    = 1'b1;
            tx_rp_nxt = mcurb_pkg::inc_tx(tx_rp);
          end else begin
            irq_nxt = 1'b0;
          end
        end
      end
      mcurb_pkg::OP_PUT: begin
        if (mcurb_pkg::inc_tx(tx_wp) == tx_rp) begin
          ovf = 1'b1;
        end else begin
          tx_we     = 1'b1;
          tx_wp_nxt = mcurb_pkg::inc_tx(tx_wp);
        end
        irq_nxt = 1'b1;
      end
      mcurb_pkg::OP_GET: begin
        if (rx_rp != rx_wp) begin
          rbyte     = rx_rdata_r;
          rvalid    = 1'b1;
          rx_rp_nxt = mcurb_pkg::inc_rx(rx_rp);
        end
      end
      mcurb_pkg::OP_CLEAR: begin
        rx_wp_nxt = '0;
        rx_rp_nxt = '0;
        tx_wp_nxt = '0;
        tx_rp_nxt = '0;
      end
      default: begin
        rx_we = 1'b0;
      end
    endcase

    rx_we    = rx_we && ch_ok && cmd.commit;
    tx_we    = tx_we && ch_ok && cmd.commit;
    rx_empty = (rx_rp_nxt == rx_wp_nxt);

    free_w = mcurb_pkg::FREE_CALC_W'(tx_wp_nxt);
    free_r = mcurb_pkg::FREE_CALC_W'(tx_rp_nxt);
    if (free_r > free_w) begin
      free_calc = free_r - free_w - mcurb_pkg::FREE_CALC_W'(1);
    end else begin
      free_calc = mcurb_pkg::FREE_CALC_W'(mcurb_pkg::TX_DEPTH) - (free_w - free_r)
                  - mcurb_pkg::FREE_CALC_W'(1);
    end
    if (free_calc > mcurb_pkg::FREE_CALC_W'(mcurb_pkg::FREE_MAX)) begin
      free_sat = mcurb_pkg::FREE_W'(mcurb_pkg::FREE_MAX);
    end else begin
      free_sat = free_calc[mcurb_pkg::FREE_W-1:0];
    end

    if (ch_ok) begin
      tdata_nxt = {5'b0, ovf, dropped, free_sat, rx_empty, irq_nxt, sbyte, rbyte};
      tuser_nxt = {svalid, rvalid};
    end else begin
      tdata_nxt = '0;
      tuser_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mcurb_pkg::CHANNELS; i++) begin
        rx_wp_r[i] <= '0;
        rx_rp_r[i] <= '0;
        tx_wp_r[i] <= '0;
        tx_rp_r[i] <= '0;
        irq_r[i]   <= 1'b0;
      end
    end else if (cmd.commit && ch_ok) begin
      rx_wp_r[ch_r] <= rx_wp_nxt;
      rx_rp_r[ch_r] <= rx_rp_nxt;
      tx_wp_r[ch_r] <= tx_wp_nxt;
      tx_rp_r[ch_r] <= tx_rp_nxt;
      irq_r[ch_r]   <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tdata_r <= tdata_nxt;
      out_tuser_r <= tuser_nxt;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

/* bench/mcurb_result_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel UART ring buffers: result checker
// Watches the request and result streams of the core. Every accepted request
// goes through a behavioral model of the per-channel receive and transmit
// rings. The predicted result is queued, and each accepted result is compared
// field by field with the oldest prediction. The failure count and the
// coverage counters go back to the testbench top.
// ----------------------------------------------------------------------------

module mcurb_result_check
  import mcurb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          drop_count,
  output int          overflow_count,
  output int          read_count,
  output int          send_count
);

  typedef struct {
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              send_valid;
    logic              tx_irq_enable;
    logic              rx_empty;
    logic [FREE_W-1:0] tx_free;
    logic              rx_dropped_oldest;
    logic              tx_overflow;
  } line_result_t;

  logic [BYTE_W-1:0] rx_ring [CHANNELS][RX_DEPTH];
  logic [BYTE_W-1:0] tx_ring [CHANNELS][TX_DEPTH];
  int                rx_wr [CHANNELS];
  int                rx_rd [CHANNELS];
  int                tx_wr [CHANNELS];
  int                tx_rd [CHANNELS];
  logic              tx_irq [CHANNELS];

  line_result_t expected_results[$];

  function automatic line_result_t apply_request(item_t req);
    line_result_t r;
    int           ch;
    int           space;
    r = '{default: '0};
    ch = req.channel;
    case (req.opcode)
      OP_LINE: begin
        if (req.status_errors == '0 && req.status_received) begin
          rx_ring[ch][rx_wr[ch]] = req.data_in;
          rx_wr[ch] = (rx_wr[ch] + 1) % RX_DEPTH;
          if (rx_wr[ch] == rx_rd[ch]) begin
            rx_rd[ch] = (rx_rd[ch] + 1) % RX_DEPTH;
            r.rx_dropped_oldest = 1'b1;
          end
        end
        if (req.status_tx_empty) begin
          if (tx_rd[ch] != tx_wr[ch]) begin
            r.send_byte = tx_ring[ch][tx_rd[ch]];
            r.send_valid = 1'b1;
            tx_rd[ch] = (tx_rd[ch] + 1) % TX_DEPTH;
          end else begin
            tx_irq[ch] = 1'b0;
          end
        end
      end
      OP_PUT: begin
        if ((tx_wr[ch] + 1) % TX_DEPTH == tx_rd[ch]) begin
          r.tx_overflow = 1'b1;
        end else begin
          tx_ring[ch][tx_wr[ch]] = req.data_in;
          tx_wr[ch] = (tx_wr[ch] + 1) % TX_DEPTH;
        end
        tx_irq[ch] = 1'b1;
      end
      OP_GET: begin
        if (rx_rd[ch] != rx_wr[ch]) begin
          r.read_byte = rx_ring[ch][rx_rd[ch]];
          r.read_valid = 1'b1;
          rx_rd[ch] = (rx_rd[ch] + 1) % RX_DEPTH;
        end
      end
      OP_CLEAR: begin
        rx_wr[ch] = 0;
        rx_rd[ch] = 0;
        tx_wr[ch] = 0;
        tx_rd[ch] = 0;
      end
      default: ;
    endcase
    if (tx_rd[ch] > tx_wr[ch]) begin
      space = tx_rd[ch] - tx_wr[ch] - 1;
    end else begin
      space = TX_DEPTH - (tx_wr[ch] - tx_rd[ch]) - 1;
    end
    r.tx_free = FREE_W'((space > FREE_MAX) ? FREE_MAX : space);
    r.tx_irq_enable = tx_irq[ch];
    r.rx_empty = (rx_rd[ch] == rx_wr[ch]);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      if (fail_count < 10) begin
        $display("MISMATCH result %0d, %s: expected %0d, got %0d",
                 result_count, name, want, got);
      end
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    item_t        req;
    line_result_t want;
    line_result_t got;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rx_wr[c] = 0;
        rx_rd[c] = 0;
        tx_wr[c] = 0;
        tx_rd[c] = 0;
        tx_irq[c] = 1'b0;
      end
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
      drop_count = 0;
      overflow_count = 0;
      read_count = 0;
      send_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_byte         = out_tdata[7:0];
        got.send_byte         = out_tdata[15:8];
        got.tx_irq_enable     = out_tdata[16];
        got.rx_empty          = out_tdata[17];
        got.tx_free           = out_tdata[24:18];
        got.rx_dropped_oldest = out_tdata[25];
        got.tx_overflow       = out_tdata[26];
        got.read_valid        = out_tuser[0];
        got.send_valid        = out_tuser[1];
        if (expected_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("UNEXPECTED result %0d: no request is waiting for it", result_count);
          end
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("read_valid", want.read_valid, got.read_valid);
          check_field("send_byte", want.send_byte, got.send_byte);
          check_field("send_valid", want.send_valid, got.send_valid);
          check_field("tx_irq_enable", want.tx_irq_enable, got.tx_irq_enable);
          check_field("rx_empty", want.rx_empty, got.rx_empty);
          check_field("tx_free", want.tx_free, got.tx_free);
          check_field("rx_dropped_oldest", want.rx_dropped_oldest, got.rx_dropped_oldest);
          check_field("tx_overflow", want.tx_overflow, got.tx_overflow);
          drop_count += want.rx_dropped_oldest;
          overflow_count += want.tx_overflow;
          read_count += want.read_valid;
          send_count += want.send_valid;
        end
        result_count++;
      end
      if (in_tvalid && in_tready) begin
        req.opcode          = in_tuser[1:0];
        req.channel         = in_tuser[3:2];
        req.status_received = in_tdata[0];
        req.status_errors   = in_tdata[4:1];
        req.status_tx_empty = in_tdata[5];
        req.data_in         = in_tdata[13:6];
        expected_results.push_back(apply_request(req));
      end
    end
    pending = expected_results.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel UART ring buffers: testbench top
// Drives requests into the core and applies backpressure on its results.
// A short directed sequence covers every operation, the error flags and the
// empty-ring cases; random traffic then floods one transmit ring past full
// and one receive ring past full, mixed with noise on the other channels.
// The result checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
  import mcurb_pkg::*;

  typedef enum {MIX_TRAFFIC, TX_FLOOD, RX_FLOOD} traffic_t;

  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  int fail_count;
  int pending;
  int result_count;
  int drop_count;
  int overflow_count;
  int read_count;
  int send_count;
  int sent;
  bit quiet;
  bit hold_done;

  always #5 clk = ~clk;

  multichannel_uart_ring_buffers_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mcurb_result_check result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .pending        (pending),
    .result_count   (result_count),
    .drop_count     (drop_count),
    .overflow_count (overflow_count),
    .read_count     (read_count),
    .send_count     (send_count)
  );

  function automatic item_t make_request(logic [1:0] op, int ch, logic rcv,
                                         logic [ERR_W-1:0] err, logic txe,
                                         logic [BYTE_W-1:0] data);
    item_t req;
    req.opcode          = op;
    req.channel         = CH_W'(ch);
    req.status_received = rcv;
    req.status_errors   = err;
    req.status_tx_empty = txe;
    req.data_in         = data;
    return req;
  endfunction

  function automatic item_t mixed_request(int ch);
    item_t req;
    int    pick;
    pick = $urandom_range(0, 99);
    req = make_request(OP_CLEAR, ch, 1'($urandom_range(0, 1)), ERR_W'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
    if (pick < 40) begin
      req.opcode = OP_LINE;
      req.status_received = ($urandom_range(0, 3) != 0);
      req.status_errors = ($urandom_range(0, 4) == 0) ? ERR_W'($urandom_range(1, 15)) : '0;
    end else if (pick < 68) begin
      req.opcode = OP_PUT;
    end else if (pick < 96) begin
      req.opcode = OP_GET;
    end
    return req;
  endfunction

  function automatic item_t flood_request(traffic_t kind, int focus);
    int share;
    share = (kind == TX_FLOOD) ? 90 : 97;
    if ($urandom_range(0, 99) >= share) begin
      return mixed_request((focus + $urandom_range(1, CHANNELS - 1)) % CHANNELS);
    end
    if (kind == TX_FLOOD) begin
      return make_request(OP_PUT, focus, 1'($urandom_range(0, 1)),
                          ERR_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          BYTE_W'($urandom_range(0, 255)));
    end
    return make_request(OP_LINE, focus, 1'b1, '0, 1'($urandom_range(0, 1)),
                        BYTE_W'($urandom_range(0, 255)));
  endfunction

  task automatic send_request(item_t req);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {req.channel, req.opcode};
    in_tdata  <= {2'b00, req.data_in, req.status_tx_empty, req.status_errors,
                  req.status_received};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic run_traffic(traffic_t kind, int focus, int count);
    for (int i = 0; i < count; i++) begin
      if (kind == MIX_TRAFFIC) begin
        send_request(mixed_request($urandom_range(0, CHANNELS - 1)));
      end else begin
        send_request(flood_request(kind, focus));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_request(make_request(OP_GET,   0, 1'b0, 4'h0, 1'b0, 8'h00));
    send_request(make_request(OP_LINE,  0, 1'b0, 4'h0, 1'b1, 8'h00));
    send_request(make_request(OP_PUT,   0, 1'b0, 4'h0, 1'b0, 8'hFF));
    send_request(make_request(OP_PUT,   0, 1'b1, 4'hF, 1'b1, 8'h00));
    send_request(make_request(OP_LINE,  0, 1'b1, 4'h0, 1'b1, 8'hA5));
    send_request(make_request(OP_LINE,  0, 1'b1, 4'hF, 1'b0, 8'h5A));
    for (int e = 0; e < ERR_W; e++) begin
      send_request(make_request(OP_LINE, 2, 1'b1, ERR_W'(1 << e), 1'b0, 8'hC3));
    end
    send_request(make_request(OP_LINE,  0, 1'b0, 4'h0, 1'b1, 8'h00));
    send_request(make_request(OP_LINE,  0, 1'b0, 4'h0, 1'b1, 8'h00));
    send_request(make_request(OP_GET,   0, 1'b0, 4'h0, 1'b0, 8'h00));
    send_request(make_request(OP_GET,   0, 1'b1, 4'hF, 1'b1, 8'hFF));
    send_request(make_request(OP_LINE,  1, 1'b1, 4'h0, 1'b0, 8'hFF));
    send_request(make_request(OP_LINE,  3, 1'b1, 4'h0, 1'b0, 8'h00));
    send_request(make_request(OP_PUT,   3, 1'b0, 4'h0, 1'b0, 8'h3C));
    send_request(make_request(OP_CLEAR, 3, 1'b0, 4'h0, 1'b0, 8'h00));
    send_request(make_request(OP_LINE,  3, 1'b0, 4'h0, 1'b1, 8'h00));
    send_request(make_request(OP_GET,   1, 1'b0, 4'h0, 1'b0, 8'h00));
    send_request(make_request(OP_PUT,   2, 1'b0, 4'h0, 1'b0, 8'h81));
    send_request(make_request(OP_LINE,  2, 1'b1, 4'h0, 1'b1, 8'h7E));

    run_traffic(TX_FLOOD, 1, 150);
    run_traffic(MIX_TRAFFIC, 0, 120);
    run_traffic(RX_FLOOD, 3, 1080);
    quiet = 1'b1;
    run_traffic(MIX_TRAFFIC, 0, 80);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d requests over %0d channels; %0d results checked.",
             sent, CHANNELS, result_count);
    $display("Receive-ring drops %0d, refused puts %0d, bytes read %0d, bytes sent %0d.",
             drop_count, overflow_count, read_count, send_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    forever begin
      if (!hold_done && result_count >= 300) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d results still outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
